// File: hw/rtl/bxds_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the byte translate/delete/squeeze filter.
// No dependencies.
package bxds_pkg;

	localparam int BYTE_W    = 8;
	localparam int KEY_COUNT = 256;

	// configuration register indexes
	localparam logic REG_DELETE_MODE  = 1'b0;
	localparam logic REG_SQUEEZE_MODE = 1'b1;

	typedef enum logic [1:0] {
		OP_MARK_DEL = 2'd0,
		OP_MARK_SQZ = 2'd1,
		OP_SET_REPL = 2'd2,
		OP_DATA     = 2'd3
	} op_t;

	// One map entry: squeeze mark, delete mark, replacement byte.
	typedef struct packed {
		logic              sqz;
		logic              del;
		logic [BYTE_W-1:0] repl;
	} entry_t;

	// Item as classified by the front and carried through the queue.
	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] key;
		logic [BYTE_W-1:0] val;
	} item_t;

	typedef struct packed {
		logic del_mode;
		logic sqz_mode;
	} modes_t;

endpackage

// File: hw/rtl/byte_translate_delete_squeeze.sv
`timescale 1ns / 1ps
// Top level of the byte translate/delete/squeeze filter.
// Depends on bxds_pkg, bxds_front, bxds_queue and bxds_back.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   cmd, key_byte, value_byte
//   out      out_valid / out_stall out_byte
//   cfg      cfg_we                cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; a kept data byte passes
// through the queue slot, the registered table read and the output register.
// Reset clears the queue, the marks of the map (it reads as identity) and the
// last-emitted record; no clearing pass is needed.
// The queue absorbs back-side stalls; in_stall rises only when it is full.
module byte_translate_delete_squeeze
	import bxds_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [BYTE_W-1:0] key_byte,
	input  logic [BYTE_W-1:0] value_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic              cfg_data
);

	modes_t modes_q;
	logic   q_full;
	logic   q_push;
	item_t  q_in;
	logic   q_pop;
	logic   head_valid;
	item_t  head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELETE_MODE:  modes_q.del_mode <= cfg_data;
				REG_SQUEEZE_MODE: modes_q.sqz_mode <= cfg_data;
			endcase
		end
	end

	bxds_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.key_byte   (key_byte),
		.value_byte (value_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (q_in)
	);

	bxds_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	bxds_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.modes      (modes_q),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte)
	);

endmodule

// File: hw/rtl/bxds_front.sv
`timescale 1ns / 1ps
// Front: input handshake and command classification.
// Depends on bxds_pkg; feeds bxds_queue.
module bxds_front
	import bxds_pkg::*;
(
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [BYTE_W-1:0] key_byte,
	input  logic [BYTE_W-1:0] value_byte,
	input  logic              q_full,
	output logic              q_push,
	output item_t             q_item
);

	op_t op;

	always_comb begin
		unique case (cmd)
			OP_MARK_DEL: op = OP_MARK_DEL;
			OP_MARK_SQZ: op = OP_MARK_SQZ;
			OP_SET_REPL: op = OP_SET_REPL;
			default:     op = OP_DATA;
		endcase
	end

	assign in_stall   = q_full;
	assign q_push     = in_valid & ~q_full;
	assign q_item.op  = op;
	assign q_item.key = key_byte;
	// value only matters for a replacement write
	assign q_item.val = (op == OP_SET_REPL) ? value_byte : '0;

endmodule

// File: hw/rtl/bxds_queue.sv
`timescale 1ns / 1ps
// Short item queue between front and back.
// Depends on bxds_pkg.
module bxds_queue
	import bxds_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/bxds_back.sv
`timescale 1ns / 1ps
// Back: map table, entry update, delete/squeeze decision and output register.
// Depends on bxds_pkg; takes items from bxds_queue.
module bxds_back
	import bxds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  modes_t            modes,
	input  logic              head_valid,
	input  item_t             head_item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte
);

	entry_t              map_mem [KEY_COUNT];
	logic [KEY_COUNT-1:0] written_q;

	logic              v_s1;
	op_t               op_s1;
	logic [BYTE_W-1:0] key_s1;
	logic [BYTE_W-1:0] val_s1;
	entry_t            rd_s1;
	logic              rd_written_s1;

	logic              fwd_v_q;
	logic [BYTE_W-1:0] fwd_key_q;
	entry_t            fwd_ent_q;

	entry_t            last_q;
	logic              last_v_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;

	entry_t ent;
	entry_t new_ent;
	logic   drop;
	logic   emit;
	logic   adv;
	logic   wr_en;
	logic   fire;

	always_comb begin
		priority if (fwd_v_q && fwd_key_q == key_s1) begin
			ent = fwd_ent_q;
		end else if (rd_written_s1) begin
			ent = rd_s1;
		end else begin
			ent = '{sqz: 1'b0, del: 1'b0, repl: key_s1};
		end
	end

	always_comb begin
		unique case (op_s1)
			OP_MARK_DEL: new_ent = '{sqz: 1'b0, del: 1'b1, repl: key_s1};
			OP_MARK_SQZ: new_ent = '{sqz: 1'b1, del: ent.del, repl: ent.repl};
			OP_SET_REPL: new_ent = '{sqz: ent.sqz, del: ent.del, repl: val_s1};
			default:     new_ent = ent;
		endcase
	end

	assign drop  = (modes.del_mode & ent.del)
		| (modes.sqz_mode & ent.sqz & last_v_q & (last_q == ent));
	assign emit  = (op_s1 == OP_DATA) & ~drop;
	assign adv   = ~v_s1 | ~emit | ~out_valid_q | ~out_stall;
	assign pop   = adv & head_valid;
	assign wr_en = v_s1 & adv & (op_s1 != OP_DATA);
	assign fire  = v_s1 & adv & emit;

	// table write and registered read; read returns the old entry on a clash
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[key_s1] <= new_ent;
		end
		if (pop) begin
			rd_s1 <= map_mem[head_item.key];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1     <= head_item.op;
			key_s1    <= head_item.key;
			val_s1    <= head_item.val;
			fwd_key_q <= key_s1;
			fwd_ent_q <= new_ent;
		end
		if (fire) begin
			last_q     <= ent;
			out_byte_q <= ent.repl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q     <= '0;
			rd_written_s1 <= 1'b0;
			v_s1          <= 1'b0;
			fwd_v_q       <= 1'b0;
			last_v_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[key_s1] <= 1'b1;
			end
			if (pop) begin
				rd_written_s1 <= written_q[head_item.key];
				fwd_v_q       <= wr_en;
			end
			if (adv) begin
				v_s1 <= head_valid;
			end
			if (fire) begin
				last_v_q    <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

endmodule
